@@ src/polycen_pkg.sv @@
// Shared types and constants of the polygon centroid block.
package polycen_pkg;

   localparam int COORD_W    = 16;
   localparam int AREA_W     = 44;
   localparam int MOM_W      = 61;
   localparam int OUT_AREA_W = 43;
   localparam int CROSS_W    = 2 * COORD_W + 1;
   localparam int MUL_A_W    = COORD_W + 1;
   localparam int MUL_B_W    = CROSS_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int DVS_W      = AREA_W + 2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_MUL4,
      S_MUL5,
      S_DPREP,
      S_DX_GO,
      S_DX_WAIT,
      S_DY_GO,
      S_DY_WAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MOM_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MOM_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ src/polycen_div.sv @@
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module polycen_div (
   input  logic                       clock,
   input  logic                       reset,
   input  polycen_pkg::div_req_type   req,
   output polycen_pkg::div_rsp_type   rsp
);

   localparam int CNT_W = $clog2(polycen_pkg::MOM_W + 1);

   logic                            busy_ff;
   logic                            done_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [polycen_pkg::DVS_W-1:0]   rem_ff;
   logic [polycen_pkg::DVS_W-1:0]   dvs_ff;
   logic [polycen_pkg::MOM_W-1:0]   quo_ff;
   logic [polycen_pkg::DVS_W:0]     trial;
   logic [polycen_pkg::DVS_W:0]     diff;
   logic                            ge;

   assign trial = {rem_ff, quo_ff[polycen_pkg::MOM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(polycen_pkg::MOM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         dvs_ff <= req.divisor;
         quo_ff <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[polycen_pkg::DVS_W-1:0] : trial[polycen_pkg::DVS_W-1:0];
         quo_ff <= {quo_ff[polycen_pkg::MOM_W-2:0], ge};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

@@ src/polygon_centroid.sv @@
// Polygon centroid by the shoelace sums, with a shared multiplier and a serial divider.
//
//  channel | dir | tdata (low bit up)                        | tuser      | tlast
//  req     | in  | x[15:0], y[31:16]                         | -          | last vertex
//  rsp     | out | centroid_x[15:0], centroid_y[31:16],      | degenerate | -
//          |     | twice_area[74:32], zero pad [79:75]       |            |
//
// A vertex takes the accept and the six steps S_MUL0 to S_MUL5 of the one 17x34 multiplier;
// the first vertex of a polygon, unless it is also the last, takes only the accept.
// The last vertex adds the six steps again for the closing edge, a prep step in S_DPREP
// and two divider runs (skipped at zero area), then the result waits in S_OUT.
// req_tready is high only in S_IDLE; a stalled result holds the block.
// Reset is synchronous and clears the sums and the first-vertex flag.
module polygon_centroid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x, y
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // centroid_x, centroid_y, twice_area, pad
   output logic        rsp_tuser    // degenerate
);

   localparam int CW = polycen_pkg::COORD_W;

   polycen_pkg::state_type state_ff, state_in;

   logic                                have_first_ff;
   logic                                closing_ff;
   logic                                last_ff;
   logic signed [CW-1:0]                first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CW-1:0]                ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [polycen_pkg::AREA_W-1:0]   area_sum_ff;
   logic signed [polycen_pkg::MOM_W-1:0]    mom_x_ff, mom_y_ff;
   logic signed [polycen_pkg::PROD_W-1:0]   prod_ff, hold_ff;
   logic signed [polycen_pkg::CROSS_W-1:0]  cross_ff;
   logic [polycen_pkg::DVS_W-1:0]           dmag_ff;
   logic                                    dneg_ff;
   logic signed [CW-1:0]                    cx_ff, cy_ff;
   logic signed [polycen_pkg::OUT_AREA_W-1:0] area_out_ff;
   logic                                    degen_ff;

   logic signed [CW-1:0]                    in_x, in_y;
   logic                                    accept;
   logic                                    area_zero;
   logic signed [polycen_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [polycen_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [polycen_pkg::PROD_W-1:0]   mul_p;
   logic signed [polycen_pkg::DVS_W-1:0]    dsum;
   logic signed [polycen_pkg::MOM_W-1:0]    mom_sel;
   logic                                    div_start;
   polycen_pkg::div_req_type                div_req;
   polycen_pkg::div_rsp_type                div_rsp;

   function automatic logic signed [CW-1:0] sat_q(
      input logic [polycen_pkg::MOM_W-1:0] mag,
      input logic                          neg
   );
      logic signed [CW-1:0] r;
      if (neg) begin
         if (mag > polycen_pkg::MOM_W'(2 ** (CW - 1))) begin
            r = {1'b1, {(CW-1){1'b0}}};
         end else begin
            r = -$signed(mag[CW-1:0]);
         end
      end else begin
         if (mag > polycen_pkg::MOM_W'(2 ** (CW - 1) - 1)) begin
            r = {1'b0, {(CW-1){1'b1}}};
         end else begin
            r = $signed(mag[CW-1:0]);
         end
      end
      return r;
   endfunction

   assign in_x      = req_tdata[CW-1:0];
   assign in_y      = req_tdata[2*CW-1:CW];
   assign accept    = req_tvalid && req_tready;
   assign area_zero = (area_sum_ff == '0);
   assign mul_p     = mul_a * mul_b;
   assign dsum      = polycen_pkg::DVS_W'(area_sum_ff)
                    + (polycen_pkg::DVS_W'(area_sum_ff) <<< 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         polycen_pkg::S_IDLE: begin
            if (accept && (have_first_ff || req_tlast)) begin
               state_in = polycen_pkg::S_MUL0;
            end
         end
         polycen_pkg::S_MUL0: state_in = polycen_pkg::S_MUL1;
         polycen_pkg::S_MUL1: state_in = polycen_pkg::S_MUL2;
         polycen_pkg::S_MUL2: state_in = polycen_pkg::S_MUL3;
         polycen_pkg::S_MUL3: state_in = polycen_pkg::S_MUL4;
         polycen_pkg::S_MUL4: state_in = polycen_pkg::S_MUL5;
         polycen_pkg::S_MUL5: begin
            if (closing_ff) begin
               state_in = polycen_pkg::S_DPREP;
            end else if (last_ff) begin
               state_in = polycen_pkg::S_MUL0;
            end else begin
               state_in = polycen_pkg::S_IDLE;
            end
         end
         polycen_pkg::S_DPREP: begin
            state_in = area_zero ? polycen_pkg::S_OUT : polycen_pkg::S_DX_GO;
         end
         polycen_pkg::S_DX_GO: state_in = polycen_pkg::S_DX_WAIT;
         polycen_pkg::S_DX_WAIT: begin
            if (div_rsp.done) begin
               state_in = polycen_pkg::S_DY_GO;
            end
         end
         polycen_pkg::S_DY_GO: state_in = polycen_pkg::S_DY_WAIT;
         polycen_pkg::S_DY_WAIT: begin
            if (div_rsp.done) begin
               state_in = polycen_pkg::S_OUT;
            end
         end
         polycen_pkg::S_OUT: begin
            if (rsp_tready) begin
               state_in = polycen_pkg::S_IDLE;
            end
         end
         default: state_in = polycen_pkg::S_IDLE;
      endcase
   end

   // control outputs and multiplier operand select
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_start  = 1'b0;
      mom_sel    = mom_x_ff;
      mul_a      = polycen_pkg::MUL_A_W'(ax_ff);
      mul_b      = polycen_pkg::MUL_B_W'(by_ff);
      case (state_ff)
         polycen_pkg::S_IDLE: req_tready = 1'b1;
         polycen_pkg::S_MUL1: begin
            mul_a = polycen_pkg::MUL_A_W'(bx_ff);
            mul_b = polycen_pkg::MUL_B_W'(ay_ff);
         end
         polycen_pkg::S_MUL3: begin
            mul_a = polycen_pkg::MUL_A_W'(ax_ff) + polycen_pkg::MUL_A_W'(bx_ff);
            mul_b = polycen_pkg::MUL_B_W'(cross_ff);
         end
         polycen_pkg::S_MUL4: begin
            mul_a = polycen_pkg::MUL_A_W'(ay_ff) + polycen_pkg::MUL_A_W'(by_ff);
            mul_b = polycen_pkg::MUL_B_W'(cross_ff);
         end
         polycen_pkg::S_DX_GO: div_start = 1'b1;
         polycen_pkg::S_DY_GO: begin
            div_start = 1'b1;
            mom_sel   = mom_y_ff;
         end
         polycen_pkg::S_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = mom_sel[polycen_pkg::MOM_W-1] ? -mom_sel : mom_sel;
   assign div_req.divisor  = dmag_ff;

   polycen_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // control state and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= polycen_pkg::S_IDLE;
         have_first_ff <= 1'b0;
         closing_ff    <= 1'b0;
         area_sum_ff   <= '0;
         mom_x_ff      <= '0;
         mom_y_ff      <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            polycen_pkg::S_IDLE: begin
               if (accept) begin
                  have_first_ff <= 1'b1;
                  closing_ff    <= !have_first_ff;
               end
            end
            polycen_pkg::S_MUL3: begin
               area_sum_ff <= area_sum_ff + polycen_pkg::AREA_W'(cross_ff);
            end
            polycen_pkg::S_MUL4: mom_x_ff <= mom_x_ff + polycen_pkg::MOM_W'(prod_ff);
            polycen_pkg::S_MUL5: begin
               mom_y_ff <= mom_y_ff + polycen_pkg::MOM_W'(prod_ff);
               if (!closing_ff && last_ff) begin
                  closing_ff <= 1'b1;
               end
            end
            polycen_pkg::S_OUT: begin
               if (rsp_tready) begin
                  have_first_ff <= 1'b0;
                  area_sum_ff   <= '0;
                  mom_x_ff      <= '0;
                  mom_y_ff      <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      hold_ff <= prod_ff;
      case (state_ff)
         polycen_pkg::S_IDLE: begin
            if (accept) begin
               last_ff   <= req_tlast;
               prev_x_ff <= in_x;
               prev_y_ff <= in_y;
               bx_ff     <= in_x;
               by_ff     <= in_y;
               if (have_first_ff) begin
                  ax_ff <= prev_x_ff;
                  ay_ff <= prev_y_ff;
               end else begin
                  first_x_ff <= in_x;
                  first_y_ff <= in_y;
                  ax_ff      <= in_x;
                  ay_ff      <= in_y;
               end
            end
         end
         polycen_pkg::S_MUL2: begin
            cross_ff <= hold_ff[polycen_pkg::CROSS_W-1:0] - prod_ff[polycen_pkg::CROSS_W-1:0];
         end
         polycen_pkg::S_MUL5: begin
            ax_ff <= prev_x_ff;
            ay_ff <= prev_y_ff;
            bx_ff <= first_x_ff;
            by_ff <= first_y_ff;
         end
         polycen_pkg::S_DPREP: begin
            dneg_ff  <= dsum[polycen_pkg::DVS_W-1];
            dmag_ff  <= dsum[polycen_pkg::DVS_W-1] ? -dsum : dsum;
            degen_ff <= area_zero;
            cx_ff    <= '0;
            cy_ff    <= '0;
            if (area_sum_ff[polycen_pkg::AREA_W-1] != area_sum_ff[polycen_pkg::AREA_W-2]) begin
               area_out_ff <= {area_sum_ff[polycen_pkg::AREA_W-1],
                               {(polycen_pkg::OUT_AREA_W-1){!area_sum_ff[polycen_pkg::AREA_W-1]}}};
            end else begin
               area_out_ff <= area_sum_ff[polycen_pkg::OUT_AREA_W-1:0];
            end
         end
         polycen_pkg::S_DX_WAIT: begin
            if (div_rsp.done) begin
               cx_ff <= sat_q(div_rsp.quotient, mom_x_ff[polycen_pkg::MOM_W-1] ^ dneg_ff);
            end
         end
         polycen_pkg::S_DY_WAIT: begin
            if (div_rsp.done) begin
               cy_ff <= sat_q(div_rsp.quotient, mom_y_ff[polycen_pkg::MOM_W-1] ^ dneg_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {5'b0, area_out_ff, cy_ff, cx_ff};
   assign rsp_tuser = degen_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result side active together");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && degen_ff |-> cx_ff == '0 && cy_ff == '0 && area_out_ff == '0)
      else $error("degenerate result with nonzero fields");

   a_area_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !degen_ff |-> area_out_ff != '0)
      else $error("divided result with zero area");

   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !have_first_ff && area_sum_ff == '0
                                   && mom_x_ff == '0 && mom_y_ff == '0)
      else $error("sums not cleared after result");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == polycen_pkg::S_DX_WAIT
                       || state_ff == polycen_pkg::S_DY_WAIT)
      else $error("divider finished outside a wait state");

endmodule

@@ verif/tb_polygon_centroid.sv @@
// Self-checking testbench for polygon_centroid: directed and random polygons against a built-in shoelace predictor.
module tb_polygon_centroid;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [polycen_pkg::COORD_W-1:0]    cx;
      logic signed [polycen_pkg::COORD_W-1:0]    cy;
      logic signed [polycen_pkg::OUT_AREA_W-1:0] area;
      logic                                      degen;
   } centroid_type;

   class centroid_tracker;
      longint                          first_x, first_y, prev_x, prev_y;
      logic [polycen_pkg::AREA_W-1:0]  area_sum;
      logic [polycen_pkg::MOM_W-1:0]   mom_x_sum, mom_y_sum;
      bit                              have_first;
      centroid_type                    pending_centroids[$];
      int                              errors, vertices, polygons, checked;
      int                              degenerate_seen, coord_clipped, area_clipped;

      function void clear_polygon();
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
         area_sum = '0; mom_x_sum = '0; mom_y_sum = '0;
         have_first = 0;
      endfunction

      function void add_edge(longint xa, longint ya, longint xb, longint yb);
         longint cp, mx, my;
         cp = xa * yb - xb * ya;
         mx = (xa + xb) * cp;
         my = (ya + yb) * cp;
         area_sum  = area_sum + cp[polycen_pkg::AREA_W-1:0];
         mom_x_sum = mom_x_sum + mx[polycen_pkg::MOM_W-1:0];
         mom_y_sum = mom_y_sum + my[polycen_pkg::MOM_W-1:0];
      endfunction

      function logic signed [polycen_pkg::COORD_W-1:0] clip_coord(longint v);
         longint hi, lo;
         hi = (longint'(1) <<< (polycen_pkg::COORD_W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi || v < lo) coord_clipped++;
         if (v > hi) return hi[polycen_pkg::COORD_W-1:0];
         if (v < lo) return lo[polycen_pkg::COORD_W-1:0];
         return v[polycen_pkg::COORD_W-1:0];
      endfunction

      function logic signed [polycen_pkg::OUT_AREA_W-1:0] clip_area(longint v);
         longint hi, lo;
         hi = (longint'(1) <<< (polycen_pkg::OUT_AREA_W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi || v < lo) area_clipped++;
         if (v > hi) return hi[polycen_pkg::OUT_AREA_W-1:0];
         if (v < lo) return lo[polycen_pkg::OUT_AREA_W-1:0];
         return v[polycen_pkg::OUT_AREA_W-1:0];
      endfunction

      function void add_vertex(logic signed [polycen_pkg::COORD_W-1:0] x,
                               logic signed [polycen_pkg::COORD_W-1:0] y,
                               logic last);
         longint       vx, vy, s, mx, my;
         centroid_type r;
         vx = x;
         vy = y;
         vertices++;
         if (!have_first) begin
            first_x = vx;
            first_y = vy;
            have_first = 1;
         end else begin
            add_edge(prev_x, prev_y, vx, vy);
         end
         prev_x = vx;
         prev_y = vy;
         if (!last) return;
         add_edge(vx, vy, first_x, first_y);
         s = $signed(area_sum);
         r.degen = (s == 0);
         r.cx = '0;
         r.cy = '0;
         if (!r.degen) begin
            mx = $signed(mom_x_sum);
            my = $signed(mom_y_sum);
            r.cx = clip_coord(mx / (3 * s));
            r.cy = clip_coord(my / (3 * s));
         end else begin
            degenerate_seen++;
         end
         r.area = clip_area(s);
         pending_centroids.push_back(r);
         polygons++;
         clear_polygon();
      endfunction

      task flag_mismatch(string msg);
         $display("%0t ns: MISMATCH polygon %0d: %s", $time, checked, msg);
         errors++;
      endtask

      task check_centroid(logic [79:0] data, logic user);
         centroid_type want;
         if (pending_centroids.size() == 0) begin
            flag_mismatch("centroid item with no polygon pending");
            return;
         end
         want = pending_centroids.pop_front();
         if (data[15:0] !== want.cx)
            flag_mismatch($sformatf("centroid_x got %0d want %0d",
                                    $signed(data[15:0]), want.cx));
         if (data[31:16] !== want.cy)
            flag_mismatch($sformatf("centroid_y got %0d want %0d",
                                    $signed(data[31:16]), want.cy));
         if (data[74:32] !== want.area)
            flag_mismatch($sformatf("twice_area got %0d want %0d",
                                    $signed(data[74:32]), want.area));
         if (user !== want.degen)
            flag_mismatch($sformatf("degenerate got %b want %b", user, want.degen));
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // x[15:0], y[31:16]
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [79:0] rsp_tdata;          // centroid_x[15:0], centroid_y[31:16], twice_area[74:32]
   logic        rsp_tuser;          // degenerate

   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   bit  pressure_armed = 0;
   bit  holding        = 0;
   int  long_vertices  = 0;

   centroid_tracker tracker = new();

   polygon_centroid dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Timeout: %0d polygons still pending", tracker.pending_centroids.size());
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_centroid(rsp_tdata, rsp_tuser);
      if (holding)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // long receiver hold-off; the block stalls in S_OUT and drops req_tready
   initial begin
      wait (pressure_armed);
      holding <= 1'b1;
      repeat (800) @(posedge clock);
      holding <= 1'b0;
   end

   task automatic send_vertex(input logic signed [15:0] vx, input logic signed [15:0] vy,
                              input logic vlast);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vy, vx};
      req_tlast  <= vlast;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.add_vertex(vx, vy, vlast);
   endtask

   function automatic logic signed [15:0] rand_coord(int style);
      case (style)
         0: return 16'($urandom());
         1: return 16'($urandom_range(4000) - 2000);
         default: begin
            case ($urandom_range(6))
               0: return 16'(-32768);
               1: return 16'(-32767);
               2: return 16'(-1);
               3: return 16'(0);
               4: return 16'(1);
               5: return 16'(32766);
               default: return 16'(32767);
            endcase
         end
      endcase
   endfunction

   // self-crossing quad whose lobes nearly cancel: tiny area, huge moments
   task automatic send_bowtie(int span, bit flip);
      int sg;
      sg = flip ? -1 : 1;
      send_vertex(0, 0, 0);
      send_vertex(16'(sg * span), 16'(sg * span), 0);
      send_vertex(16'(sg * span), 0, 0);
      send_vertex(0, 16'(sg * (span + 1)), 1);
   endtask

   task automatic send_random_polygon();
      int kind, n, style;
      logic signed [15:0] bx, by, dx, dy;
      kind = $urandom_range(99);
      if (kind < 6) begin
         send_vertex(rand_coord(0), rand_coord(2), 1);
      end else if (kind < 11) begin
         send_vertex(rand_coord(0), rand_coord(0), 0);
         send_vertex(rand_coord(2), rand_coord(1), 1);
      end else if (kind < 16) begin
         bx = rand_coord(1);
         by = rand_coord(1);
         dx = 16'($urandom_range(200) - 100);
         dy = 16'($urandom_range(200) - 100);
         n = $urandom_range(3, 6);
         for (int i = 0; i < n; i++)
            send_vertex(16'(bx + i * dx), 16'(by + i * dy), i == n - 1);
      end else if (kind < 22) begin
         send_bowtie($urandom_range(1, 32766), 1'($urandom_range(1)));
      end else begin
         n = (kind < 30) ? $urandom_range(11, 40) : $urandom_range(3, 10);
         style = $urandom_range(2);
         for (int i = 0; i < n; i++)
            send_vertex(rand_coord(style), rand_coord($urandom_range(3) == 0 ? 2 : style),
                        i == n - 1);
      end
   endtask

   // winds the full-range square many times: over the vertex limit
   task automatic send_winding_polygon(int n);
      for (int i = 0; i < n; i++) begin
         case (i % 4)
            0: send_vertex(32767, 32767, i == n - 1);
            1: send_vertex(-32768, 32767, i == n - 1);
            2: send_vertex(-32768, -32768, i == n - 1);
            default: send_vertex(32767, -32768, i == n - 1);
         endcase
      end
      long_vertices += n;
   endtask

   initial begin : stimulus
      int idle_plan[4];
      int stall_plan[4];
      int base;
      idle_plan  = '{0, 60, 0, 15};
      stall_plan = '{0, 0, 60, 15};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vertex(32767, -32768, 1);
      send_vertex(-32768, -32768, 0);
      send_vertex(32767, -32768, 0);
      send_vertex(32767, 32767, 0);
      send_vertex(-32768, 32767, 1);
      send_vertex(32767, 32767, 0);
      send_vertex(32767, -32768, 0);
      send_vertex(-32768, -32768, 1);
      send_vertex(0, 0, 0);
      send_vertex(16, 16, 0);
      send_vertex(32, 32, 1);
      send_vertex(-1, 1, 0);
      send_vertex(1, -1, 1);
      send_bowtie(30000, 0);
      send_bowtie(30000, 1);
      send_vertex(0, 0, 0);
      send_vertex(48, 0, 0);
      send_vertex(0, 48, 1);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct    <= stall_plan[p];
         if (p == 0) pressure_armed <= 1'b1;
         base = tracker.vertices;
         while (tracker.vertices - base < 170) send_random_polygon();
         if (p == 0) send_winding_polygon(1040);
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_centroids.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Ran %0d vertices in %0d polygons (%0d in one polygon over the vertex limit).",
               tracker.vertices, tracker.polygons, long_vertices);
      $display("Zero-area polygons: %0d, clipped centroid coordinates: %0d, clipped areas: %0d.",
               tracker.degenerate_seen, tracker.coord_clipped, tracker.area_clipped);
      if (tracker.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
src/polycen_pkg.sv
src/polycen_div.sv
src/polygon_centroid.sv
verif/tb_polygon_centroid.sv
